// File: design/ssd_pkg.sv
// Shared constants of the segment-to-segment distance pipeline.
package ssd_pkg;

	// fraction bits of the clamped closest-point parameters s and t
	localparam int QBITS = 16;

	// result width and its saturation value
	localparam int OUT_W = 25;
	localparam logic [OUT_W-1:0] OUT_MAX = '1;

	// cycles through one pipelined wide multiplier
	localparam int MUL_LAT = 4;

	// cycles through one pipelined divider: one set-up stage, one stage per quotient bit
	localparam int DIV_LAT = QBITS + 1;

endpackage

// File: design/ssd_dly.sv
// Enabled shift line that keeps side data in step with the pipeline.
module ssd_dly #(
	parameter int W = 8,
	parameter int N = 1
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);

	logic [W-1:0] tap_s [N];

	always_ff @(posedge clk) begin
		if (en) begin
			tap_s[0] <= d;
			for (int k = 1; k < N; k++) begin
				tap_s[k] <= tap_s[k-1];
			end
		end
	end

	assign q = tap_s[N-1];

endmodule

// File: design/ssd_mul.sv
// Pipelined signed multiplier built from narrow limb products.
module ssd_mul #(
	parameter int WA = 52,
	parameter int WB = 52
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic signed [WA-1:0]    a,
	input  logic signed [WB-1:0]    b,
	output logic signed [WA+WB-1:0] p
);

	localparam int LW = 24;
	localparam int NA = (WA + LW - 1) / LW;
	localparam int NB = (WB + LW - 1) / LW;
	localparam int PW = WA + WB;

	logic [WA-1:0]      abs_a;
	logic [WB-1:0]      abs_b;
	logic [NA*LW-1:0]   ma_s1;
	logic [NB*LW-1:0]   mb_s1;
	logic               neg_s1;
	logic [2*LW-1:0]    pp_s2 [NA][NB];
	logic               neg_s2;
	logic [PW-1:0]      row_c [NA];
	logic [PW-1:0]      row_s3 [NA];
	logic               neg_s3;
	logic [PW-1:0]      total_c;
	logic [PW-1:0]      p_s4;

	// work on magnitudes, put the sign back at the end
	assign abs_a = a[WA-1] ? (~a + 1'b1) : a;
	assign abs_b = b[WB-1] ? (~b + 1'b1) : b;

	always_comb begin
		for (int i = 0; i < NA; i++) begin
			row_c[i] = '0;
			for (int j = 0; j < NB; j++) begin
				row_c[i] = row_c[i] + (PW'(pp_s2[i][j]) << (LW * (i + j)));
			end
		end
		total_c = '0;
		for (int i = 0; i < NA; i++) begin
			total_c = total_c + row_s3[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ma_s1  <= (NA*LW)'(abs_a);
			mb_s1  <= (NB*LW)'(abs_b);
			neg_s1 <= a[WA-1] ^ b[WB-1];
			for (int i = 0; i < NA; i++) begin
				for (int j = 0; j < NB; j++) begin
					pp_s2[i][j] <= ma_s1[i*LW +: LW] * mb_s1[j*LW +: LW];
				end
			end
			neg_s2 <= neg_s1;
			row_s3 <= row_c;
			neg_s3 <= neg_s2;
			p_s4   <= neg_s3 ? (~total_c + 1'b1) : total_c;
		end
	end

	assign p = $signed(p_s4);

endmodule

// File: design/ssd_div.sv
// Pipelined restoring divider giving floor(num * 2^QBITS / den) for a clamped fraction.
module ssd_div #(
	parameter int WN = 105
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic signed [WN-1:0]     num,
	input  logic signed [WN-1:0]     den,
	output logic [ssd_pkg::QBITS:0]  quo
);

	localparam int NQ = ssd_pkg::QBITS;

	logic [WN-1:0] rem_s  [NQ+1];
	logic [WN-1:0] den_s  [NQ+1];
	logic [NQ-1:0] q_s    [NQ+1];
	logic          full_s [NQ+1];
	logic [WN:0]   dbl_c  [NQ];
	logic          ge_c   [NQ];
	logic          zero_c;
	logic          full_c;

	always_comb begin
		zero_c = num[WN-1] || (num == '0) || den[WN-1] || (den == '0);
		full_c = !zero_c && (num >= den);
		for (int k = 0; k < NQ; k++) begin
			dbl_c[k] = {rem_s[k], 1'b0};
			ge_c[k]  = dbl_c[k] >= {1'b0, den_s[k]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// a zero or whole quotient runs through with a remainder that yields no bits
			if (zero_c || full_c) begin
				rem_s[0] <= '0;
				den_s[0] <= WN'(1);
			end else begin
				rem_s[0] <= num;
				den_s[0] <= den;
			end
			q_s[0]    <= '0;
			full_s[0] <= full_c;
			for (int k = 0; k < NQ; k++) begin
				if (ge_c[k]) begin
					rem_s[k+1] <= WN'(dbl_c[k] - {1'b0, den_s[k]});
				end else begin
					rem_s[k+1] <= dbl_c[k][WN-1:0];
				end
				den_s[k+1]  <= den_s[k];
				q_s[k+1]    <= {q_s[k][NQ-2:0], ge_c[k]};
				full_s[k+1] <= full_s[k];
			end
		end
	end

	assign quo = {full_s[NQ], q_s[NQ]};

endmodule

// File: design/ssd_sqrt.sv
// Pipelined bitwise integer square root, one result bit per stage.
module ssd_sqrt #(
	parameter int WX = 56
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic [WX-1:0]           x,
	output logic [(WX+1)/2-1:0]     root
);

	localparam int RB = (WX + 1) / 2;
	localparam int WT = 2 * RB + 2;

	logic [WT-1:0] rem_s  [RB];
	logic [RB-1:0] root_s [RB];
	logic [WT-1:0] rem_c  [RB];
	logic [RB-1:0] rt_c   [RB];
	logic [WT-1:0] tst_c  [RB];

	always_comb begin
		rem_c[0] = WT'(x);
		rt_c[0]  = '0;
		for (int k = 1; k < RB; k++) begin
			rem_c[k] = rem_s[k-1];
			rt_c[k]  = root_s[k-1];
		end
		// (2r + 2^b) * 2^b is what setting bit b adds to r squared
		for (int k = 0; k < RB; k++) begin
			tst_c[k] = (WT'(rt_c[k]) << (RB - k)) + (WT'(1) << (2 * (RB - 1 - k)));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < RB; k++) begin
				if (rem_c[k] >= tst_c[k]) begin
					rem_s[k]  <= rem_c[k] - tst_c[k];
					root_s[k] <= rt_c[k] | (RB'(1) << (RB - 1 - k));
				end else begin
					rem_s[k]  <= rem_c[k];
					root_s[k] <= rt_c[k];
				end
			end
		end
	end

	assign root = root_s[RB-1];

endmodule

// File: design/segment_segment_distance.sv
// Top level of the pipelined shortest-distance unit for two 3D segments.
//
//  channel | valid      | stall      | payload
//  --------+------------+------------+-----------------------------------------------
//  pair    | pair_valid | pair_stall | first/second start/end x, y, z (signed Q16.8)
//  dist    | dist_valid | dist_stall | distance (unsigned Q17.8, truncated)
//
// One item enters per cycle while no result is held back; each result passes through
// the two wide multiplier pipelines, the 17-stage dividers and the one-bit-per-stage
// square root.
// Reset clears only the valid bits of the stages; data registers carry no reset.
// A stalled result holds the whole pipeline: every stage freezes and pair_stall rises
// in the same cycle, so nothing is dropped or repeated.
module segment_segment_distance #(
	parameter int COORD_WIDTH = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          pair_valid,
	output logic                          pair_stall,
	input  logic signed [COORD_WIDTH-1:0] first_start_x,
	input  logic signed [COORD_WIDTH-1:0] first_start_y,
	input  logic signed [COORD_WIDTH-1:0] first_start_z,
	input  logic signed [COORD_WIDTH-1:0] first_end_x,
	input  logic signed [COORD_WIDTH-1:0] first_end_y,
	input  logic signed [COORD_WIDTH-1:0] first_end_z,
	input  logic signed [COORD_WIDTH-1:0] second_start_x,
	input  logic signed [COORD_WIDTH-1:0] second_start_y,
	input  logic signed [COORD_WIDTH-1:0] second_start_z,
	input  logic signed [COORD_WIDTH-1:0] second_end_x,
	input  logic signed [COORD_WIDTH-1:0] second_end_y,
	input  logic signed [COORD_WIDTH-1:0] second_end_z,
	output logic                          dist_valid,
	input  logic                          dist_stall,
	output logic [ssd_pkg::OUT_W-1:0]     distance
);

	// widths: vector components, dot products, 2x2 products, offset vector, squared sum
	localparam int WD   = COORD_WIDTH + 1;
	localparam int WP   = 2 * WD + 2;
	localparam int WQ   = 2 * WP + 1;
	localparam int WC   = WD + ssd_pkg::QBITS + 2;
	localparam int WSUM = 2 * WC + 2;
	localparam int WX   = WSUM - 2 * ssd_pkg::QBITS;
	localparam int RB   = (WX + 1) / 2;

	// stage bookkeeping
	localparam int D_VEC = 2 + ssd_pkg::MUL_LAT + 3 + ssd_pkg::DIV_LAT;
	localparam int LAT   = 3 + ssd_pkg::MUL_LAT + 3 + ssd_pkg::DIV_LAT + 2
		+ ssd_pkg::MUL_LAT + 1 + RB + 1;

	// dot product slots
	localparam int UU = 0;
	localparam int UV = 1;
	localparam int VV = 2;
	localparam int UW = 3;
	localparam int VW = 4;

	logic                en;
	logic [LAT-1:0]      vld_s;

	// direction of segment one (0..2), of segment two (3..5), start offset (6..8)
	logic [8:0][WD-1:0]   vec_s1;
	logic [8:0][WD-1:0]   vec_d;
	logic [14:0][2*WD-1:0] pr_s2;
	logic [4:0][WP-1:0]   dot_s3;
	logic [4:0][WP-1:0]   dot_d;
	logic signed [2*WP-1:0] mp [6];

	logic signed [WQ-1:0] det_s8, sn_s8, tn_s8;
	logic signed [WP-1:0] uu_d, uv_d, vv_d, uw_d, vw_d;

	// edge handling, first half
	logic                 det_pos_c;
	logic signed [WP:0]   cl_c, ch_c;
	logic signed [WQ-1:0] sn_c, sd_c, tn_c, td_c;
	logic signed [WQ-1:0] sn_s9, sd_s9, tn_s9, td_s9;
	logic signed [WP:0]   cl_s9, ch_s9;
	logic signed [WP-1:0] uu_s9;
	logic                 cl_neg_s9, cl_gt_s9, ch_neg_s9, ch_gt_s9;

	// edge handling, second half
	logic                 t_neg_c, t_gt_c, c_neg_c, c_gt_c;
	logic signed [WP:0]   cand_c;
	logic signed [WQ-1:0] sn2_c, sd2_c, tn2_c, td2_c;
	logic signed [WQ-1:0] sn_s10, sd_s10, tn_s10, td_s10;

	logic [ssd_pkg::QBITS:0] sq, tq;

	logic [2:0][WC-1:0]   ps_s28, pt_s28;
	logic [2:0][WD-1:0]   dw_s28;
	logic signed [WC-1:0] c_s29 [3];
	logic signed [2*WC-1:0] sqr [3];
	logic [WSUM-1:0]      sum_c;
	logic [WX-1:0]        x_s34;
	logic [RB-1:0]        root;
	logic [RB+ssd_pkg::OUT_W-1:0] root_ext;
	logic [ssd_pkg::OUT_W-1:0]    distance_q;

	// advance everything unless a finished result is held back
	assign en         = !(vld_s[LAT-1] && dist_stall);
	assign pair_stall = !en;
	assign dist_valid = vld_s[LAT-1];
	assign distance   = distance_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[LAT-2:0], pair_valid};
		end
	end

	// s1: direction and offset vectors
	always_ff @(posedge clk) begin
		if (en) begin
			vec_s1[0] <= WD'(first_end_x) - WD'(first_start_x);
			vec_s1[1] <= WD'(first_end_y) - WD'(first_start_y);
			vec_s1[2] <= WD'(first_end_z) - WD'(first_start_z);
			vec_s1[3] <= WD'(second_end_x) - WD'(second_start_x);
			vec_s1[4] <= WD'(second_end_y) - WD'(second_start_y);
			vec_s1[5] <= WD'(second_end_z) - WD'(second_start_z);
			vec_s1[6] <= WD'(first_start_x) - WD'(second_start_x);
			vec_s1[7] <= WD'(first_start_y) - WD'(second_start_y);
			vec_s1[8] <= WD'(first_start_z) - WD'(second_start_z);
		end
	end

	// s2: component products; s3: the five dot products
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				pr_s2[UU*3+i] <= $signed(vec_s1[i]) * $signed(vec_s1[i]);
				pr_s2[UV*3+i] <= $signed(vec_s1[i]) * $signed(vec_s1[3+i]);
				pr_s2[VV*3+i] <= $signed(vec_s1[3+i]) * $signed(vec_s1[3+i]);
				pr_s2[UW*3+i] <= $signed(vec_s1[i]) * $signed(vec_s1[6+i]);
				pr_s2[VW*3+i] <= $signed(vec_s1[3+i]) * $signed(vec_s1[6+i]);
			end
			for (int d = 0; d < 5; d++) begin
				dot_s3[d] <= WP'($signed(pr_s2[3*d])) + WP'($signed(pr_s2[3*d+1]))
					+ WP'($signed(pr_s2[3*d+2]));
			end
		end
	end

	// s4..s7: the six products behind the determinant and the raw numerators
	ssd_mul #(.WA(WP), .WB(WP)) u_mul_uuvv (.clk(clk), .en(en),
		.a($signed(dot_s3[UU])), .b($signed(dot_s3[VV])), .p(mp[0]));
	ssd_mul #(.WA(WP), .WB(WP)) u_mul_uvuv (.clk(clk), .en(en),
		.a($signed(dot_s3[UV])), .b($signed(dot_s3[UV])), .p(mp[1]));
	ssd_mul #(.WA(WP), .WB(WP)) u_mul_uvvw (.clk(clk), .en(en),
		.a($signed(dot_s3[UV])), .b($signed(dot_s3[VW])), .p(mp[2]));
	ssd_mul #(.WA(WP), .WB(WP)) u_mul_vvuw (.clk(clk), .en(en),
		.a($signed(dot_s3[VV])), .b($signed(dot_s3[UW])), .p(mp[3]));
	ssd_mul #(.WA(WP), .WB(WP)) u_mul_uuvw (.clk(clk), .en(en),
		.a($signed(dot_s3[UU])), .b($signed(dot_s3[VW])), .p(mp[4]));
	ssd_mul #(.WA(WP), .WB(WP)) u_mul_uvuw (.clk(clk), .en(en),
		.a($signed(dot_s3[UV])), .b($signed(dot_s3[UW])), .p(mp[5]));

	// hold the dot products until the determinant is ready
	ssd_dly #(.W(5*WP), .N(ssd_pkg::MUL_LAT + 1)) u_dly_dot (
		.clk(clk), .en(en), .d(dot_s3), .q(dot_d));

	assign uu_d = $signed(dot_d[UU]);
	assign uv_d = $signed(dot_d[UV]);
	assign vv_d = $signed(dot_d[VV]);
	assign uw_d = $signed(dot_d[UW]);
	assign vw_d = $signed(dot_d[VW]);

	// s8: determinant and unclamped numerators
	always_ff @(posedge clk) begin
		if (en) begin
			det_s8 <= WQ'(mp[0]) - WQ'(mp[1]);
			sn_s8  <= WQ'(mp[2]) - WQ'(mp[3]);
			tn_s8  <= WQ'(mp[4]) - WQ'(mp[5]);
		end
	end

	// s9: clamp s to its edges; prepare both fallback candidates for s
	always_comb begin
		det_pos_c = !det_s8[WQ-1] && (det_s8 != '0);
		cl_c      = -((WP+1)'(uw_d));
		ch_c      = (WP+1)'(uv_d) - (WP+1)'(uw_d);
		if (!det_pos_c) begin
			// parallel or degenerate: s pinned to zero
			sn_c = '0;
			sd_c = WQ'(1);
			tn_c = WQ'(vw_d);
			td_c = WQ'(vv_d);
		end else if (sn_s8[WQ-1]) begin
			sn_c = '0;
			sd_c = det_s8;
			tn_c = WQ'(vw_d);
			td_c = WQ'(vv_d);
		end else if (sn_s8 > det_s8) begin
			sn_c = det_s8;
			sd_c = det_s8;
			tn_c = WQ'(vw_d) + WQ'(uv_d);
			td_c = WQ'(vv_d);
		end else begin
			sn_c = sn_s8;
			sd_c = det_s8;
			tn_c = tn_s8;
			td_c = det_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sn_s9     <= sn_c;
			sd_s9     <= sd_c;
			tn_s9     <= tn_c;
			td_s9     <= td_c;
			cl_s9     <= cl_c;
			ch_s9     <= ch_c;
			uu_s9     <= uu_d;
			cl_neg_s9 <= cl_c[WP];
			cl_gt_s9  <= cl_c > (WP+1)'(uu_d);
			ch_neg_s9 <= ch_c[WP];
			ch_gt_s9  <= ch_c > (WP+1)'(uu_d);
		end
	end

	// s10: clamp t; when t hits an edge, recompute s from the matching candidate
	always_comb begin
		t_neg_c = tn_s9[WQ-1];
		t_gt_c  = tn_s9 > td_s9;
		c_neg_c = t_neg_c ? cl_neg_s9 : ch_neg_s9;
		c_gt_c  = t_neg_c ? cl_gt_s9 : ch_gt_s9;
		cand_c  = t_neg_c ? cl_s9 : ch_s9;
		sn2_c   = sn_s9;
		sd2_c   = sd_s9;
		tn2_c   = tn_s9;
		td2_c   = td_s9;
		if (t_neg_c || t_gt_c) begin
			tn2_c = t_neg_c ? '0 : td_s9;
			if (c_neg_c) begin
				sn2_c = '0;
			end else if (c_gt_c) begin
				sn2_c = sd_s9;
			end else begin
				sn2_c = WQ'(cand_c);
				sd2_c = WQ'(uu_s9);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sn_s10 <= sn2_c;
			sd_s10 <= sd2_c;
			tn_s10 <= tn2_c;
			td_s10 <= td2_c;
		end
	end

	// s11..s27: fractions s and t in unsigned Q1.16, at most 1.0
	ssd_div #(.WN(WQ)) u_div_s (.clk(clk), .en(en), .num(sn_s10), .den(sd_s10), .quo(sq));
	ssd_div #(.WN(WQ)) u_div_t (.clk(clk), .en(en), .num(tn_s10), .den(td_s10), .quo(tq));

	// hold the vectors until the fractions arrive
	ssd_dly #(.W(9*WD), .N(D_VEC)) u_dly_vec (
		.clk(clk), .en(en), .d(vec_s1), .q(vec_d));

	// s28: scale the directions; s29: offset between the closest points
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				ps_s28[i] <= $signed({1'b0, sq}) * $signed(vec_d[i]);
				pt_s28[i] <= $signed({1'b0, tq}) * $signed(vec_d[3+i]);
				dw_s28[i] <= vec_d[6+i];
			end
			for (int i = 0; i < 3; i++) begin
				c_s29[i] <= (WC'($signed(dw_s28[i])) <<< ssd_pkg::QBITS)
					+ $signed(ps_s28[i]) - $signed(pt_s28[i]);
			end
		end
	end

	// s30..s33: squared components
	ssd_mul #(.WA(WC), .WB(WC)) u_mul_cx (.clk(clk), .en(en),
		.a(c_s29[0]), .b(c_s29[0]), .p(sqr[0]));
	ssd_mul #(.WA(WC), .WB(WC)) u_mul_cy (.clk(clk), .en(en),
		.a(c_s29[1]), .b(c_s29[1]), .p(sqr[1]));
	ssd_mul #(.WA(WC), .WB(WC)) u_mul_cz (.clk(clk), .en(en),
		.a(c_s29[2]), .b(c_s29[2]), .p(sqr[2]));

	// s34: squared length, dropping the extra fraction bits of s and t
	assign sum_c = WSUM'($unsigned(sqr[0])) + WSUM'($unsigned(sqr[1]))
		+ WSUM'($unsigned(sqr[2]));

	always_ff @(posedge clk) begin
		if (en) begin
			x_s34 <= sum_c[WSUM-1:2*ssd_pkg::QBITS];
		end
	end

	ssd_sqrt #(.WX(WX)) u_sqrt (.clk(clk), .en(en), .x(x_s34), .root(root));

	// output register: saturate to the result width
	assign root_ext = (RB+ssd_pkg::OUT_W)'(root);

	always_ff @(posedge clk) begin
		if (en) begin
			if (root_ext > (RB+ssd_pkg::OUT_W)'(ssd_pkg::OUT_MAX)) begin
				distance_q <= ssd_pkg::OUT_MAX;
			end else begin
				distance_q <= root_ext[ssd_pkg::OUT_W-1:0];
			end
		end
	end

	// a frozen pipeline keeps every valid bit
	a_freeze_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_s))
		else $error("valid bits moved while the pipeline was held");

	// an accepted item occupies the first stage
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		pair_valid && !pair_stall |=> vld_s[0])
		else $error("accepted item did not enter the first stage");

	// an advancing cycle without an item leaves a bubble
	a_bubble_enters: assert property (@(posedge clk) disable iff (!arst_n)
		en && !pair_valid |=> !vld_s[0])
		else $error("item appeared in the first stage from nothing");

	// the last stage before the output always reaches it on an advance
	a_reaches_output: assert property (@(posedge clk) disable iff (!arst_n)
		en && vld_s[LAT-2] |=> dist_valid)
		else $error("item was lost before the output register");

endmodule
